### rtl/pfc_pkg.sv
// Package for the frame checker: frame layout, register indexes, verdict codes
// and the CRC-32C / FNV-1a 64 byte-step functions.
// No dependencies.
`default_nettype none

package pfc_pkg;

	// Frame layout
	localparam int MAX_PAYLOAD = 65536;
	localparam int HDR_BYTES   = 16;
	localparam int TRL_BYTES   = 12;
	localparam int CRC_BYTES   = 4;
	localparam int MAGIC_BYTES = 8;
	localparam int VER_END     = 12;
	localparam int COUNT_SAT   = MAX_PAYLOAD + HDR_BYTES + TRL_BYTES + 1;
	localparam int CNT_W       = $clog2(COUNT_SAT + 1);

	// Configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;
	localparam int MAXP_W     = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN  = 8'd2;

	localparam logic [63:0]       MAGIC_RST   = 64'h0;
	localparam logic [31:0]       VERSION_RST = 32'd1;
	localparam logic [MAXP_W-1:0] MAXLEN_RST  = 17'd65536;

	// Checksums
	localparam logic [31:0] CRC_POLY  = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
	localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

	typedef enum logic [3:0] {
		VERD_OK        = 4'd0,
		VERD_SHORT_HDR = 4'd1,
		VERD_MAGIC     = 4'd2,
		VERD_VERSION   = 4'd3,
		VERD_OVERSIZE  = 4'd4,
		VERD_SHORT_PAY = 4'd5,
		VERD_TRAILING  = 4'd6,
		VERD_CRC       = 4'd7,
		VERD_HASH      = 4'd8
	} verdict_t;

	// Reflected CRC-32C, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// FNV-1a 64 step; prime 2^40 + 0x1B3 as a sum of shifts
	function automatic logic [63:0] fnv_byte(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'h0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

`default_nettype wire

### rtl/persist_frame_checker_core.sv
// Frame checker top level: input register, header/payload/trailer capture,
// running CRC-32C and FNV-1a 64, verdict and result register.
// Depends on pfc_pkg.
`default_nettype none

// Channel   Direction  Handshake              Payload
// ------    ---------  ---------------------  ------------------------------
// input     in         in_valid / in_stall    data_byte, last_byte
// result    out        out_valid / out_stall  verdict, declared_length
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte per cycle sustained; a request is taken every cycle unless a final
// byte sits in the input register while an earlier verdict is still stalled.
// The verdict passes through the input register and then the result register
// before it shows on the result port; the CRC step and shift-add FNV step set
// the path.
// Reset (arst_n low) clears frame state and loads register reset values.
// A stalled verdict holds; non-final bytes keep flowing past it.

module persist_frame_checker_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          last_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [3:0]                         verdict,
	output logic [31:0]                        declared_length,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [pfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pfc_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = pfc_pkg::CNT_W;

	// Configuration registers
	logic [63:0]                  magic_cfg_q;
	logic [31:0]                  version_cfg_q;
	logic [pfc_pkg::MAXP_W-1:0]   maxlen_cfg_q;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Frame state
	logic [CW-1:0] cnt_q;
	logic [63:0]   magic_q;
	logic [31:0]   version_q;
	logic [31:0]   len_q;
	logic [31:0]   crc_q;
	logic [63:0]   fnv_q;
	logic [31:0]   tcrc_q;
	logic [63:0]   thash_q;

	// Result register
	logic               out_valid_q;
	pfc_pkg::verdict_t  verdict_q;
	logic [31:0]        plen_q;

	// Next-state values
	logic [CW-1:0] cnt_nx;
	logic [63:0]   magic_nx;
	logic [31:0]   version_nx;
	logic [31:0]   len_nx;
	logic [31:0]   crc_nx;
	logic [63:0]   fnv_nx;
	logic [31:0]   tcrc_nx;
	logic [63:0]   thash_nx;
	logic [CW-1:0] rel;
	logic [CW-1:0] off;
	logic [CW-1:0] off_h;
	logic          in_pay;
	logic [31:0]   bound;
	logic [32:0]   expect_n;
	logic [32:0]   n33;
	pfc_pkg::verdict_t verd_nx;

	logic advance;
	logic out_take;

	assign cfg_ready = 1'b1;

	// Register writes take effect at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_cfg_q   <= pfc_pkg::MAGIC_RST;
			version_cfg_q <= pfc_pkg::VERSION_RST;
			maxlen_cfg_q  <= pfc_pkg::MAXLEN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				pfc_pkg::CFG_MAGIC:   magic_cfg_q   <= cfg_data;
				pfc_pkg::CFG_VERSION: version_cfg_q <= cfg_data[31:0];
				pfc_pkg::CFG_MAXLEN:  maxlen_cfg_q  <= cfg_data[pfc_pkg::MAXP_W-1:0];
				default: ;
			endcase
		end
	end

	// A final byte must wait only while a previous verdict is stalled
	assign out_take = out_valid_q && !out_stall;
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Byte capture and running sums for the byte in the input register
	always_comb begin
		magic_nx   = magic_q;
		version_nx = version_q;
		len_nx     = len_q;
		crc_nx     = crc_q;
		fnv_nx     = fnv_q;
		tcrc_nx    = tcrc_q;
		thash_nx   = thash_q;
		cnt_nx     = cnt_q;

		// Position relative to payload start; only used past the header
		rel    = cnt_q - CW'(pfc_pkg::HDR_BYTES);
		in_pay = len_q > 32'(rel);
		off    = rel - len_q[CW-1:0];
		off_h  = off - CW'(pfc_pkg::CRC_BYTES);

		if (32'(cnt_q) < 32'(pfc_pkg::COUNT_SAT)) begin
			cnt_nx = cnt_q + CW'(1);
			if (cnt_q < CW'(pfc_pkg::MAGIC_BYTES)) begin
				magic_nx[8*cnt_q[2:0] +: 8] = byte_s1;
			end else if (cnt_q < CW'(pfc_pkg::VER_END)) begin
				version_nx[8*cnt_q[1:0] +: 8] = byte_s1;
			end else if (cnt_q < CW'(pfc_pkg::HDR_BYTES)) begin
				len_nx[8*cnt_q[1:0] +: 8] = byte_s1;
			end else if (in_pay) begin
				crc_nx = pfc_pkg::crc_byte(crc_q, byte_s1);
				fnv_nx = pfc_pkg::fnv_byte(fnv_q, byte_s1);
			end else if (off < CW'(pfc_pkg::CRC_BYTES)) begin
				tcrc_nx[8*off[1:0] +: 8] = byte_s1;
			end else if (off < CW'(pfc_pkg::TRL_BYTES)) begin
				thash_nx[8*off_h[2:0] +: 8] = byte_s1;
			end
		end
	end

	// Verdict in priority order, from the state that includes this byte
	always_comb begin
		if (32'(maxlen_cfg_q) > 32'(pfc_pkg::MAX_PAYLOAD)) begin
			bound = 32'(pfc_pkg::MAX_PAYLOAD);
		end else begin
			bound = 32'(maxlen_cfg_q);
		end
		n33      = 33'(cnt_nx);
		expect_n = 33'(pfc_pkg::HDR_BYTES + pfc_pkg::TRL_BYTES) + {1'b0, len_nx};

		if (n33 < 33'(pfc_pkg::HDR_BYTES + pfc_pkg::TRL_BYTES)) begin
			verd_nx = pfc_pkg::VERD_SHORT_HDR;
		end else if (magic_nx != magic_cfg_q) begin
			verd_nx = pfc_pkg::VERD_MAGIC;
		end else if (version_nx != version_cfg_q) begin
			verd_nx = pfc_pkg::VERD_VERSION;
		end else if (len_nx > bound) begin
			verd_nx = pfc_pkg::VERD_OVERSIZE;
		end else if (n33 < expect_n) begin
			verd_nx = pfc_pkg::VERD_SHORT_PAY;
		end else if (n33 > expect_n) begin
			verd_nx = pfc_pkg::VERD_TRAILING;
		end else if (tcrc_nx != ~crc_nx) begin
			verd_nx = pfc_pkg::VERD_CRC;
		end else if (thash_nx != fnv_nx) begin
			verd_nx = pfc_pkg::VERD_HASH;
		end else begin
			verd_nx = pfc_pkg::VERD_OK;
		end
	end

	// Advance frame state; clear it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			magic_q   <= '0;
			version_q <= '0;
			len_q     <= '0;
			crc_q     <= pfc_pkg::CRC_INIT;
			fnv_q     <= pfc_pkg::FNV_BASIS;
			tcrc_q    <= '0;
			thash_q   <= '0;
		end else if (advance) begin
			if (last_s1) begin
				cnt_q     <= '0;
				magic_q   <= '0;
				version_q <= '0;
				len_q     <= '0;
				crc_q     <= pfc_pkg::CRC_INIT;
				fnv_q     <= pfc_pkg::FNV_BASIS;
				tcrc_q    <= '0;
				thash_q   <= '0;
			end else begin
				cnt_q     <= cnt_nx;
				magic_q   <= magic_nx;
				version_q <= version_nx;
				len_q     <= len_nx;
				crc_q     <= crc_nx;
				fnv_q     <= fnv_nx;
				tcrc_q    <= tcrc_nx;
				thash_q   <= thash_nx;
			end
		end
	end

	// Result register: load on a final byte, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			verdict_q <= verd_nx;
			plen_q    <= (verd_nx == pfc_pkg::VERD_SHORT_HDR) ? 32'h0 : len_nx;
		end
	end

	assign out_valid       = out_valid_q;
	assign verdict         = verdict_q;
	assign declared_length = plen_q;

	// Checks on the block's own logic
	a_short_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (verdict == pfc_pkg::VERD_SHORT_HDR) |-> declared_length == 32'h0)
		else $error("short-header verdict with nonzero length");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> (cnt_q == '0) && (crc_q == pfc_pkg::CRC_INIT)
			&& (fnv_q == pfc_pkg::FNV_BASIS))
		else $error("frame state not cleared after final byte");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked verdict");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_s1 && (32'(cnt_q) == 32'(pfc_pkg::COUNT_SAT))
			|=> 32'(cnt_q) == 32'(pfc_pkg::COUNT_SAT))
		else $error("byte count left saturation");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking bench for persist_frame_checker_core: framed images in, one verdict per image out.
// Scores every verdict against an in-bench frame tracker; depends on pfc_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;

	localparam int unsigned FRAME_MIN     = pfc_pkg::HDR_BYTES + pfc_pkg::TRL_BYTES;
	localparam logic [63:0] FNV_PRIME64   = 64'h0000_0100_0000_01B3;
	// input register plus result register, with margin
	localparam int          SETTLE_CYCLES = 4;
	localparam int          RANDOM_BYTES  = 400;
	localparam int          RANDOM_FRAMES = 8;

	typedef struct packed {
		pfc_pkg::verdict_t verdict;
		logic [31:0]       length;
	} verdict_rec_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_COMB
	} stall_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [7:0]                     data_byte;
	logic                           last_byte;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [3:0]                     verdict;
	logic [31:0]                    declared_length;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pfc_pkg::CFG_DATA_W-1:0] cfg_data;

	persist_frame_checker_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.verdict         (verdict),
		.declared_length (declared_length),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #10 clk = ~clk;

	// Shadow copy of the configuration registers
	logic [63:0]                shadow_magic;
	logic [31:0]                shadow_version;
	logic [pfc_pkg::MAXP_W-1:0] shadow_maxlen;

	// Tracked frame state
	int unsigned seen_count;
	logic [63:0] cap_magic;
	logic [31:0] cap_version;
	logic [31:0] cap_length;
	logic [31:0] sum_crc;
	logic [63:0] sum_fnv;
	logic [31:0] cap_tcrc;
	logic [63:0] cap_thash;

	verdict_rec_t expected_verdicts[$];
	logic [7:0]   frame_buf[$];
	int           err_count   = 0;
	int           bytes_sent  = 0;
	int           burst_left  = 0;
	bit           steady_feed = 1'b0;
	int           hold_req    = 0;

	// Reflected CRC-32C, one data bit at a time
	function automatic logic [31:0] crc32c_next(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		logic        fb;
		r = c;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ b[k];
			r  = r >> 1;
			if (fb) begin
				r = r ^ pfc_pkg::CRC_POLY;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] fnv1a_next(input logic [63:0] h, input logic [7:0] b);
		return (h ^ {56'h0, b}) * FNV_PRIME64;
	endfunction

	task automatic clear_frame_state();
		seen_count  = 0;
		cap_magic   = '0;
		cap_version = '0;
		cap_length  = '0;
		sum_crc     = pfc_pkg::CRC_INIT;
		sum_fnv     = pfc_pkg::FNV_BASIS;
		cap_tcrc    = '0;
		cap_thash   = '0;
	endtask

	// Append one byte to the image under construction
	task automatic put_byte(input logic [7:0] b);
		frame_buf.insert(frame_buf.size(), b);
	endtask

	// Advance the tracked frame by one accepted byte; on the final byte queue the verdict
	task automatic track_frame_byte(input logic [7:0] b, input logic fin);
		longint unsigned idx;
		longint unsigned pay_end;
		longint unsigned want_n;
		int unsigned     bound;
		int              sel;
		verdict_rec_t    rec;
		if (seen_count < pfc_pkg::COUNT_SAT) begin
			idx     = 64'(seen_count);
			pay_end = 64'(pfc_pkg::HDR_BYTES) + 64'(cap_length);
			if (idx < pfc_pkg::MAGIC_BYTES) begin
				sel = int'(idx);
				cap_magic[8*sel +: 8] = b;
			end else if (idx < pfc_pkg::VER_END) begin
				sel = int'(idx) - pfc_pkg::MAGIC_BYTES;
				cap_version[8*sel +: 8] = b;
			end else if (idx < pfc_pkg::HDR_BYTES) begin
				sel = int'(idx) - pfc_pkg::VER_END;
				cap_length[8*sel +: 8] = b;
			end else if (idx < pay_end) begin
				sum_crc = crc32c_next(sum_crc, b);
				sum_fnv = fnv1a_next(sum_fnv, b);
			end else if (idx < pay_end + pfc_pkg::CRC_BYTES) begin
				sel = int'(idx - pay_end);
				cap_tcrc[8*sel +: 8] = b;
			end else if (idx < pay_end + pfc_pkg::TRL_BYTES) begin
				sel = int'(idx - pay_end) - pfc_pkg::CRC_BYTES;
				cap_thash[8*sel +: 8] = b;
			end
			seen_count++;
		end
		if (fin) begin
			bound  = (shadow_maxlen > pfc_pkg::MAX_PAYLOAD) ? pfc_pkg::MAX_PAYLOAD
				: shadow_maxlen;
			want_n = 64'(pfc_pkg::HDR_BYTES) + 64'(cap_length) + 64'(pfc_pkg::TRL_BYTES);
			if (seen_count < FRAME_MIN)
				rec.verdict = pfc_pkg::VERD_SHORT_HDR;
			else if (cap_magic != shadow_magic)
				rec.verdict = pfc_pkg::VERD_MAGIC;
			else if (cap_version != shadow_version)
				rec.verdict = pfc_pkg::VERD_VERSION;
			else if (cap_length > bound)
				rec.verdict = pfc_pkg::VERD_OVERSIZE;
			else if (64'(seen_count) < want_n)
				rec.verdict = pfc_pkg::VERD_SHORT_PAY;
			else if (64'(seen_count) > want_n)
				rec.verdict = pfc_pkg::VERD_TRAILING;
			else if (cap_tcrc != ~sum_crc)
				rec.verdict = pfc_pkg::VERD_CRC;
			else if (cap_thash != sum_fnv)
				rec.verdict = pfc_pkg::VERD_HASH;
			else
				rec.verdict = pfc_pkg::VERD_OK;
			rec.length = (rec.verdict == pfc_pkg::VERD_SHORT_HDR) ? 32'h0 : cap_length;
			expected_verdicts.insert(expected_verdicts.size(), rec);
			clear_frame_state();
		end
	endtask

	// Fill frame_buf with header, payload, trailer and any trailing junk
	task automatic build_frame(input logic [63:0] magic, input logic [31:0] ver,
			input logic [31:0] decl, input int pay_n, input bit bad_crc,
			input bit bad_hash, input int extra);
		logic [31:0] crc;
		logic [63:0] h;
		logic [7:0]  b;
		frame_buf.delete();
		for (int i = 0; i < 8; i++) put_byte(magic[8*i +: 8]);
		for (int i = 0; i < 4; i++) put_byte(ver[8*i +: 8]);
		for (int i = 0; i < 4; i++) put_byte(decl[8*i +: 8]);
		crc = pfc_pkg::CRC_INIT;
		h   = pfc_pkg::FNV_BASIS;
		for (int i = 0; i < pay_n; i++) begin
			b = 8'($urandom);
			put_byte(b);
			crc = crc32c_next(crc, b);
			h   = fnv1a_next(h, b);
		end
		crc = ~crc;
		if (bad_crc) crc = crc ^ (32'h1 << $urandom_range(0, 31));
		if (bad_hash) h = h ^ (64'h1 << $urandom_range(0, 63));
		for (int i = 0; i < 4; i++) put_byte(crc[8*i +: 8]);
		for (int i = 0; i < 8; i++) put_byte(h[8*i +: 8]);
		for (int i = 0; i < extra; i++) put_byte(8'($urandom));
	endtask

	task automatic drop_tail(input int k);
		repeat (k) begin
			if (frame_buf.size() > 1) void'(frame_buf.pop_back());
		end
	endtask

	// Offer one request and hold it until taken
	task automatic send_byte(input logic [7:0] b, input logic fin);
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (in_stall);
		track_frame_byte(b, fin);
		bytes_sent++;
	endtask

	// Unless steady_feed is set, bursts of random length separated by random gaps
	task automatic pace_sender();
		int gap;
		if (!steady_feed) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 40);
			end
			burst_left--;
		end
	endtask

	// Send frame_buf[lo..hi-1]; the final byte of the buffer carries the mark
	task automatic send_span(input int lo, input int hi);
		for (int i = lo; i < hi; i++) begin
			pace_sender();
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		end
	endtask

	task automatic send_frame();
		send_span(0, frame_buf.size());
	endtask

	task automatic send_good(input int len);
		build_frame(shadow_magic, shadow_version, 32'(len), len, 1'b0, 1'b0, 0);
		send_frame();
	endtask

	// Drop valid, wait for every verdict, then let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [pfc_pkg::CFG_IDX_W-1:0] idx,
			input logic [pfc_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pfc_pkg::CFG_MAGIC:   shadow_magic   = val;
			pfc_pkg::CFG_VERSION: shadow_version = val[31:0];
			pfc_pkg::CFG_MAXLEN:  shadow_maxlen  = val[pfc_pkg::MAXP_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver: a long hold when asked, else a stall pattern that changes now and then
	stall_mode_t rx_mode   = STALL_NONE;
	int          rx_left   = 0;
	int          hold_left = 0;
	int          rx_phase  = 0;

	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		rx_phase++;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (rx_left == 0) begin
				rx_mode = stall_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(16, 128);
			end
			rx_left--;
			case (rx_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 1);
				default:     out_stall <= ((rx_phase % 8) < 3);
			endcase
		end
	end

	// Score each verdict against the oldest expectation
	always @(posedge clk) begin
		verdict_rec_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_verdicts.size() == 0) begin
				$error("verdict %0d with length %0d arrived with nothing expected",
					verdict, declared_length);
				err_count++;
			end else begin
				want = expected_verdicts.pop_front();
				if (verdict !== want.verdict) begin
					$error("verdict expected %0d actual %0d", want.verdict, verdict);
					err_count++;
				end
				if (declared_length !== want.length) begin
					$error("declared_length expected %0d actual %0d", want.length,
						declared_length);
					err_count++;
				end
			end
		end
	end

	// Register reset values; every verdict code and both ends of the length field
	task automatic test_verdict_codes();
		send_good(0);
		send_good(5);
		frame_buf.delete();
		put_byte(8'($urandom));
		send_frame();
		// header complete but image below the minimum: still short header
		build_frame(shadow_magic, shadow_version, 32'h0000_ABCD, 0, 1'b0, 1'b0, 0);
		drop_tail(1);
		send_frame();
		build_frame(64'hFFFF_FFFF_FFFF_FFFF, shadow_version, 3, 3, 1'b0, 1'b0, 0);
		send_frame();
		build_frame(shadow_magic, 32'hFFFF_FFFF, 3, 3, 1'b0, 1'b0, 0);
		send_frame();
		build_frame(shadow_magic, shadow_version, 32'd65537, 0, 1'b0, 1'b0, 0);
		send_frame();
		// huge declared length must not wrap the frame positions
		build_frame(shadow_magic, shadow_version, 32'hFFFF_FFFF, 2, 1'b0, 1'b0, 0);
		send_frame();
		build_frame(shadow_magic, shadow_version, 10, 5, 1'b0, 1'b0, 0);
		send_frame();
		build_frame(shadow_magic, shadow_version, 3, 3, 1'b0, 1'b0, 3);
		send_frame();
		build_frame(shadow_magic, shadow_version, 7, 7, 1'b1, 1'b0, 0);
		send_frame();
		build_frame(shadow_magic, shadow_version, 7, 7, 1'b0, 1'b1, 0);
		send_frame();
		build_frame(shadow_magic, shadow_version, 7, 7, 1'b1, 1'b1, 0);
		send_frame();
		settle();
	endtask

	// Register extremes, the clamped bound and an unused index
	task automatic test_config_extremes();
		cfg_write(pfc_pkg::CFG_MAGIC, 64'hFFFF_FFFF_FFFF_FFFF);
		cfg_write(pfc_pkg::CFG_VERSION, 64'h0000_0000_FFFF_FFFF);
		cfg_write(pfc_pkg::CFG_MAXLEN, 64'd0);
		send_good(0);
		send_good(1);
		build_frame(64'h0, shadow_version, 0, 0, 1'b0, 1'b0, 0);
		send_frame();
		settle();
		// bound above the parameter clamps to it
		cfg_write(pfc_pkg::CFG_MAXLEN, 64'h1_FFFF);
		build_frame(shadow_magic, shadow_version, 32'd65537, 0, 1'b0, 1'b0, 0);
		send_frame();
		build_frame(shadow_magic, shadow_version, 32'd65536, 3, 1'b0, 1'b0, 0);
		send_frame();
		settle();
		cfg_write(8'hFF, {$urandom, $urandom});
		send_good(2);
		settle();
		cfg_write(pfc_pkg::CFG_MAGIC, {$urandom, $urandom});
		cfg_write(pfc_pkg::CFG_VERSION, 64'd0);
		cfg_write(pfc_pkg::CFG_MAXLEN, 64'd65536);
		send_good(4);
		settle();
	endtask

	// A write between bytes of one image counts for its verdict
	task automatic test_mid_image_config();
		build_frame(shadow_magic, 32'd9, 6, 6, 1'b0, 1'b0, 0);
		send_span(0, 10);
		settle();
		cfg_write(pfc_pkg::CFG_VERSION, 64'd9);
		send_span(10, frame_buf.size());
		build_frame(shadow_magic, shadow_version, 30, 30, 1'b0, 1'b0, 0);
		send_span(0, 20);
		settle();
		cfg_write(pfc_pkg::CFG_MAXLEN, 64'd10);
		send_span(20, frame_buf.size());
		settle();
		cfg_write(pfc_pkg::CFG_MAXLEN, 64'd65536);
	endtask

	// Hold the result side off while short images keep coming, so the core backs up
	task automatic test_backpressure();
		steady_feed = 1'b1;
		hold_req    = 400;
		repeat (10) send_good($urandom_range(0, 12));
		steady_feed = 1'b0;
		settle();
	endtask

	task automatic random_reconfig();
		case ($urandom_range(0, 3))
			0: cfg_write(pfc_pkg::CFG_MAGIC, 64'h0);
			1: cfg_write(pfc_pkg::CFG_MAGIC, 64'hFFFF_FFFF_FFFF_FFFF);
			default: cfg_write(pfc_pkg::CFG_MAGIC, {$urandom, $urandom});
		endcase
		if ($urandom_range(0, 1) == 1) cfg_write(pfc_pkg::CFG_VERSION, 64'($urandom));
		else cfg_write(pfc_pkg::CFG_VERSION, 64'($urandom_range(0, 3)));
		case ($urandom_range(0, 4))
			0: cfg_write(pfc_pkg::CFG_MAXLEN, 64'd0);
			1: cfg_write(pfc_pkg::CFG_MAXLEN, 64'($urandom_range(20, 300)));
			2: cfg_write(pfc_pkg::CFG_MAXLEN, 64'd65536);
			3: cfg_write(pfc_pkg::CFG_MAXLEN, 64'h1_FFFF);
			default: cfg_write(pfc_pkg::CFG_MAXLEN, 64'($urandom_range(0, 17'h1_FFFF)));
		endcase
	endtask

	// Mostly well-formed images with random content, the rest broken images and noise
	task automatic test_random_frames();
		int          start_bytes;
		int          frames;
		int          kind;
		int          len;
		logic [31:0] decl;
		logic [63:0] magic;
		logic [31:0] ver;
		start_bytes = bytes_sent;
		frames      = 0;
		while (bytes_sent - start_bytes < RANDOM_BYTES || frames < RANDOM_FRAMES) begin
			if (frames % 10 == 0) begin
				settle();
				random_reconfig();
			end
			steady_feed = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				len   = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 300)
					: $urandom_range(0, 40);
				magic = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : shadow_magic;
				ver   = ($urandom_range(0, 19) == 0) ? $urandom : shadow_version;
				decl  = len;
				if ($urandom_range(0, 14) == 0) decl = len + $urandom_range(1, 3);
				else if ($urandom_range(0, 14) == 0 && len > 0) decl = len - 1;
				build_frame(magic, ver, decl, len, $urandom_range(0, 9) == 0,
					$urandom_range(0, 9) == 0,
					($urandom_range(0, 14) == 0) ? $urandom_range(1, 4) : 0);
				if ($urandom_range(0, 14) == 0) drop_tail($urandom_range(1, 20));
			end else if (kind < 85) begin
				decl = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 50);
				build_frame(shadow_magic, shadow_version, decl, $urandom_range(0, 40),
					1'b0, 1'b0, $urandom_range(0, 2));
				if ($urandom_range(0, 3) == 0) drop_tail($urandom_range(1, 30));
			end else begin
				frame_buf.delete();
				repeat ($urandom_range(1, 60)) put_byte(8'($urandom));
			end
			send_frame();
			frames++;
		end
		steady_feed = 1'b0;
		settle();
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_byte = 8'h0;
		last_byte = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		shadow_magic   = pfc_pkg::MAGIC_RST;
		shadow_version = pfc_pkg::VERSION_RST;
		shadow_maxlen  = pfc_pkg::MAXLEN_RST;
		clear_frame_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_verdict_codes();
		test_config_extremes();
		test_mid_image_config();
		test_backpressure();
		test_random_frames();

		settle();
		repeat (8) @(posedge clk);
		if (err_count == 0 && expected_verdicts.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
rtl/pfc_pkg.sv
rtl/persist_frame_checker_core.sv
tb/tb.sv
